>>> hw/rtl/dlt_pkg.sv
`default_nettype none
package dlt_pkg;

   localparam int DEG_DIV = 45;
   localparam int FRAC_BITS = 13;
   localparam logic [26:0] RECIP_45 = 27'((64'd1 << 32) / 64'(DEG_DIV));
   localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
   localparam logic signed [33:0] ONE_Q30 = 34'sh040000000;

   typedef logic [FRAC_BITS-1:0] dlt_frac_tab_type [64];
   typedef logic [31:0] dlt_atan_tab_type [32];

   typedef struct packed {
      logic signed [31:0] offset;
      logic signed [31:0] length;
   } dlt_len_type;

   typedef struct packed {
      logic signed [33:0] z;
      logic               flip;
   } dlt_ang_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic               flip;
   } dlt_trig_type;

   function automatic dlt_frac_tab_type build_frac_tab();
      dlt_frac_tab_type t;
      for (int i = 0; i < 64; i++) begin
         if (i < DEG_DIV) begin
            t[i] = FRAC_BITS'((i * 8192 + 22) / DEG_DIV);
         end else begin
            t[i] = '0;
         end
      end
      return t;
   endfunction

   localparam dlt_frac_tab_type FRAC_TAB = build_frac_tab();

   localparam dlt_atan_tab_type ATAN_TAB = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

endpackage
`default_nettype wire

>>> hw/rtl/dlt_angle.sv
`default_nettype none
module dlt_angle
   import dlt_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire logic signed [1:0][25:0] in_deg,
   input  wire dlt_len_type             in_len,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output dlt_ang_type [1:0]            out_ang,
   output dlt_len_type                  out_len
);

   localparam int STAGES = 4;

   logic [STAGES-1:0] v_ff;
   logic [STAGES:0]   en;
   dlt_len_type       len_ff [STAGES];

   logic [25:0] mag1_ff  [2];
   logic        sgn1_ff  [2];
   logic [52:0] prod1_ff [2];
   logic [20:0] q2_ff    [2];
   logic [6:0]  rem2_ff  [2];
   logic        sgn2_ff  [2];
   logic [31:0] b3_ff    [2];
   logic        sgn3_ff  [2];
   dlt_ang_type ang4_ff  [2];

   assign en[STAGES] = out_ready;
   for (genvar k = 0; k < STAGES; k++) begin : g_en
      assign en[k] = !v_ff[k] || en[k+1];
   end
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < STAGES; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) len_ff[0] <= in_len;
      for (int k = 1; k < STAGES; k++) begin
         if (en[k]) len_ff[k] <= len_ff[k-1];
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [25:0] mag1_in;
      logic        ge;
      logic [20:0] q3_in;
      logic [5:0]  rem3_in;
      logic [31:0] ang_in;
      logic        flip_in;

      assign mag1_in = in_deg[l][25] ? 26'(-in_deg[l]) : 26'(in_deg[l]);
      assign ge      = rem2_ff[l] >= 7'(DEG_DIV);
      assign q3_in   = q2_ff[l] + 21'(ge);
      assign rem3_in = ge ? 6'(rem2_ff[l] - 7'(DEG_DIV)) : rem2_ff[l][5:0];
      assign ang_in  = sgn3_ff[l] ? -b3_ff[l] : b3_ff[l];
      assign flip_in = ($signed(ang_in) > 32'sh40000000) ||
                       ($signed(ang_in) < -32'sh40000000);

      always_ff @(posedge clock) begin
         if (en[0]) begin
            mag1_ff[l]  <= mag1_in;
            sgn1_ff[l]  <= in_deg[l][25];
            prod1_ff[l] <= 53'(mag1_in) * 53'(RECIP_45);
         end
         if (en[1]) begin
            q2_ff[l]   <= prod1_ff[l][52:32];
            rem2_ff[l] <= 7'(27'(mag1_ff[l]) - 27'(prod1_ff[l][52:32]) * 27'(DEG_DIV));
            sgn2_ff[l] <= sgn1_ff[l];
         end
         if (en[2]) begin
            b3_ff[l]   <= {q3_in[18:0], FRAC_TAB[rem3_in]};
            sgn3_ff[l] <= sgn2_ff[l];
         end
         if (en[3]) begin
            ang4_ff[l].z    <= 34'($signed(flip_in ? {~ang_in[31], ang_in[30:0]} : ang_in));
            ang4_ff[l].flip <= flip_in;
         end
      end

      assign out_ang[l] = ang4_ff[l];
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_len   = len_ff[STAGES-1];

endmodule
`default_nettype wire

>>> hw/rtl/dlt_cordic.sv
`default_nettype none
module dlt_cordic
   import dlt_pkg::*;
#(
   parameter int CORDIC_STAGES = 24
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire dlt_ang_type [1:0] in_ang,
   input  wire dlt_len_type      in_len,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output dlt_trig_type [1:0]    out_trig,
   output dlt_len_type           out_len
);

   logic [CORDIC_STAGES-1:0] v_ff;
   logic [CORDIC_STAGES:0]   en;
   dlt_len_type              len_ff [CORDIC_STAGES];
   logic signed [33:0]       x_ff [CORDIC_STAGES][2];
   logic signed [33:0]       y_ff [CORDIC_STAGES][2];
   logic signed [33:0]       z_ff [CORDIC_STAGES][2];
   logic                     f_ff [CORDIC_STAGES][2];

   assign en[CORDIC_STAGES] = out_ready;
   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_en
      assign en[k] = !v_ff[k] || en[k+1];
   end
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < CORDIC_STAGES; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) len_ff[0] <= in_len;
      for (int k = 1; k < CORDIC_STAGES; k++) begin
         if (en[k]) len_ff[k] <= len_ff[k-1];
      end
   end

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic signed [33:0] xp, yp, zp, at;
         logic               fp;

         if (k == 0) begin : g_first
            assign xp = CORDIC_GAIN;
            assign yp = '0;
            assign zp = in_ang[l].z;
            assign fp = in_ang[l].flip;
         end else begin : g_next
            assign xp = x_ff[k-1][l];
            assign yp = y_ff[k-1][l];
            assign zp = z_ff[k-1][l];
            assign fp = f_ff[k-1][l];
         end
         assign at = $signed({2'b00, ATAN_TAB[k]});

         always_ff @(posedge clock) begin
            if (en[k]) begin
               if (!zp[33]) begin
                  x_ff[k][l] <= xp - (yp >>> k);
                  y_ff[k][l] <= yp + (xp >>> k);
                  z_ff[k][l] <= zp - at;
               end else begin
                  x_ff[k][l] <= xp + (yp >>> k);
                  y_ff[k][l] <= yp - (xp >>> k);
                  z_ff[k][l] <= zp + at;
               end
               f_ff[k][l] <= fp;
            end
         end

         if (k == CORDIC_STAGES - 1) begin : g_out
            assign out_trig[l].x    = x_ff[k][l];
            assign out_trig[l].y    = y_ff[k][l];
            assign out_trig[l].flip = f_ff[k][l];
         end
      end
   end

   assign out_valid = v_ff[CORDIC_STAGES-1];
   assign out_len   = len_ff[CORDIC_STAGES-1];

endmodule
`default_nettype wire

>>> hw/rtl/dlt_product.sv
`default_nettype none
module dlt_product
   import dlt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire dlt_trig_type [1:0] in_trig,
   input  wire dlt_len_type       in_len,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [11:0][31:0]      out_fields
);

   localparam int STAGES = 3;

   logic [STAGES-1:0] v_ff;
   logic [STAGES:0]   en;

   logic signed [31:0] st1_ff, ct1_ff, sa1_ff, ca1_ff;
   dlt_len_type        len1_ff;
   logic signed [31:0] st2_ff, ct2_ff, sa2_ff, ca2_ff, d2_ff;
   logic signed [63:0] p_stca_ff, p_stsa_ff, p_ctca_ff, p_ctsa_ff, p_rct_ff, p_rst_ff;
   logic [11:0][31:0]  out_ff;

   function automatic logic signed [31:0] trig_fix(input logic signed [33:0] v,
                                                   input logic flip);
      logic signed [33:0] c;
      c = (v > ONE_Q30) ? ONE_Q30 : ((v < -ONE_Q30) ? -ONE_Q30 : v);
      if (flip) c = -c;
      return c[31:0];
   endfunction

   function automatic logic [31:0] rnd_q30(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = (p + 64'sd536870912) >>> 30;
      return s[31:0];
   endfunction

   function automatic logic [31:0] rnd_pos(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = (p + 64'sd536870912) >>> 30;
      if (s > 64'sd2147483647) return 32'h7FFFFFFF;
      if (s < -64'sd2147483648) return 32'h80000000;
      return s[31:0];
   endfunction

   assign en[STAGES] = out_ready;
   for (genvar k = 0; k < STAGES; k++) begin : g_en
      assign en[k] = !v_ff[k] || en[k+1];
   end
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < STAGES; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ct1_ff  <= trig_fix(in_trig[0].x, in_trig[0].flip);
         st1_ff  <= trig_fix(in_trig[0].y, in_trig[0].flip);
         ca1_ff  <= trig_fix(in_trig[1].x, in_trig[1].flip);
         sa1_ff  <= trig_fix(in_trig[1].y, in_trig[1].flip);
         len1_ff <= in_len;
      end
      if (en[1]) begin
         st2_ff    <= st1_ff;
         ct2_ff    <= ct1_ff;
         sa2_ff    <= sa1_ff;
         ca2_ff    <= ca1_ff;
         d2_ff     <= len1_ff.offset;
         p_stca_ff <= 64'(st1_ff) * 64'(ca1_ff);
         p_stsa_ff <= 64'(st1_ff) * 64'(sa1_ff);
         p_ctca_ff <= 64'(ct1_ff) * 64'(ca1_ff);
         p_ctsa_ff <= 64'(ct1_ff) * 64'(sa1_ff);
         p_rct_ff  <= 64'(len1_ff.length) * 64'(ct1_ff);
         p_rst_ff  <= 64'(len1_ff.length) * 64'(st1_ff);
      end
      if (en[2]) begin
         out_ff[0]  <= ct2_ff;
         out_ff[1]  <= -rnd_q30(p_stca_ff);
         out_ff[2]  <= rnd_q30(p_stsa_ff);
         out_ff[3]  <= rnd_pos(p_rct_ff);
         out_ff[4]  <= st2_ff;
         out_ff[5]  <= rnd_q30(p_ctca_ff);
         out_ff[6]  <= -rnd_q30(p_ctsa_ff);
         out_ff[7]  <= rnd_pos(p_rst_ff);
         out_ff[8]  <= '0;
         out_ff[9]  <= sa2_ff;
         out_ff[10] <= ca2_ff;
         out_ff[11] <= d2_ff;
      end
   end

   assign out_valid  = v_ff[STAGES-1];
   assign out_fields = out_ff;

endmodule
`default_nettype wire

>>> hw/rtl/dh_link_transform.sv
// throughput: one item per cycle while rsp_tready does not stall the output, set by the
// fully pipelined cordic and multiplier stages
// every stage holds its item under stall and empty stages fill while the output waits
// reset: synchronous, clears all stage valid bits; the pipeline is empty afterwards
`default_nettype none
module dh_link_transform
   import dlt_pkg::*;
#(
   parameter int CORDIC_STAGES = 24
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // link_offset, joint_angle, link_length, link_twist, zero pad
   input  wire logic [119:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // rot_r0c0, rot_r0c1, rot_r0c2, pos_x, rot_r1c0, rot_r1c1, rot_r1c2, pos_y,
   // rot_r2c0, rot_r2c1, rot_r2c2, pos_z
   output logic [383:0]      rsp_tdata
);

   logic                     a_valid, a_ready, c_valid, c_ready;
   logic signed [1:0][25:0]  deg;
   dlt_len_type              len_in, a_len, c_len;
   dlt_ang_type [1:0]        a_ang;
   dlt_trig_type [1:0]       c_trig;
   logic [11:0][31:0]        fields;

   assign deg[0]        = req_tdata[57:32];
   assign deg[1]        = req_tdata[115:90];
   assign len_in.offset = req_tdata[31:0];
   assign len_in.length = req_tdata[89:58];

   dlt_angle u_angle (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_deg    (deg),
      .in_len    (len_in),
      .out_valid (a_valid),
      .out_ready (a_ready),
      .out_ang   (a_ang),
      .out_len   (a_len)
   );

   dlt_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid),
      .in_ready  (a_ready),
      .in_ang    (a_ang),
      .in_len    (a_len),
      .out_valid (c_valid),
      .out_ready (c_ready),
      .out_trig  (c_trig),
      .out_len   (c_len)
   );

   dlt_product u_product (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (c_valid),
      .in_ready   (c_ready),
      .in_trig    (c_trig),
      .in_len     (c_len),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_fields (fields)
   );

   assign rsp_tdata = fields;

endmodule
`default_nettype wire

>>> hw/rtl/dlt_checker.sv
`default_nettype none
module dlt_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [383:0] rsp_tdata
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp item present after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp item changed");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled with empty output");

   a_zero_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[287:256] == 32'h0)
      else $error("bottom-left rotation entry not zero");

   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[31:0]) <= 32'sh40000000) &&
                     ($signed(rsp_tdata[31:0]) >= -32'sh40000000))
      else $error("cosine entry out of range");

endmodule

bind dh_link_transform dlt_checker u_dlt_checker (.*);
`default_nettype wire

>>> sim/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STAGES = 24;
   localparam int LATENCY = STAGES + 7;
   localparam int N_RANDOM = 1200;
   localparam longint Q30 = 64'sd1073741824;
   localparam longint HALF = 64'sd2147483648;
   localparam longint QUARTER = 64'sd1073741824;
   localparam longint GAIN = 64'sh26DD3B6A;
   localparam int DEG360 = 23592960;

   typedef struct packed {
      logic signed [25:0] twist;
      logic signed [31:0] length;
      logic signed [25:0] angle;
      logic signed [31:0] offset;
   } link_type;

   typedef struct {
      logic [31:0] f [12];
   } frame_type;

   typedef struct {
      link_type    link;
      bit          fixed;
      logic [31:0] rot20;
      logic [31:0] pos_x;
      logic [31:0] pos_z;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [119:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [383:0] rsp_tdata;

   frame_type    frame_q [$];
   int           n_errors = 0;
   bit           calm = 1'b0;

   longint atan_tab [32] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
      'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
      'h00000001, 'h00000000
   };

   dh_link_transform #(.CORDIC_STAGES(STAGES)) i_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic void deg_sincos(longint a, output longint s, output longint c);
      longint mag, b, z, x, y, dx, dy;
      bit flip;
      mag = a < 0 ? -a : a;
      b = ((mag * 8192 + 22) / 45) & 64'hFFFFFFFF;
      if (a < 0) b = (-b) & 64'hFFFFFFFF;
      z = b >= HALF ? b - 2 * HALF : b;
      flip = 1'b0;
      x = GAIN;
      y = 0;
      if (z > QUARTER) begin
         z -= HALF;
         flip = 1'b1;
      end else if (z < -QUARTER) begin
         z += HALF;
         flip = 1'b1;
      end
      for (int i = 0; i < (STAGES > 32 ? 32 : STAGES); i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[i];
         end else begin
            x += dx; y -= dy; z += atan_tab[i];
         end
      end
      x = clip(x, -Q30, Q30);
      y = clip(y, -Q30, Q30);
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return (a * b + (Q30 >>> 1)) >>> 30;
   endfunction

   function automatic frame_type link_transform(link_type l);
      frame_type t;
      longint st, ct, sa, ca, r;
      deg_sincos(longint'(l.angle), st, ct);
      deg_sincos(longint'(l.twist), sa, ca);
      r = longint'(l.length);
      t.f[0] = ct[31:0];
      t.f[1] = 32'(-qmul(st, ca));
      t.f[2] = 32'(qmul(st, sa));
      t.f[3] = 32'(clip(qmul(r, ct), -HALF, HALF - 1));
      t.f[4] = st[31:0];
      t.f[5] = 32'(qmul(ct, ca));
      t.f[6] = 32'(-qmul(ct, sa));
      t.f[7] = 32'(clip(qmul(r, st), -HALF, HALF - 1));
      t.f[8] = '0;
      t.f[9] = sa[31:0];
      t.f[10] = ca[31:0];
      t.f[11] = l.offset;
      return t;
   endfunction

   task automatic report_mismatch(string what, int idx, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s field %0d: got %h want %h at %0t", what, idx, got, want, $time);
      n_errors++;
   endtask

   task automatic send_link(link_type l);
      while (!calm && $urandom_range(99) < 26) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata <= {4'h0, l};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      frame_q.push_back(link_transform(l));
      @(negedge clock);
   endtask

   function automatic logic [25:0] rand_angle();
      case ($urandom_range(3))
         0: return 26'($signed($urandom_range(2 * DEG360)) - DEG360);
         1: return 26'($signed($urandom_range(180 * 65536)) - 90 * 65536);
         2: return 26'(($signed($urandom_range(16)) - 8) * 45 * 65536);
         default: return 26'($urandom);
      endcase
   endfunction

   always @(negedge clock) begin
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
   end

   always @(posedge clock) begin
      frame_type want;
      logic [31:0] got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (frame_q.size() == 0) begin
            $display("unexpected rsp item at %0t", $time);
            n_errors++;
         end else begin
            want = frame_q.pop_front();
            for (int i = 0; i < 12; i++) begin
               got = rsp_tdata[32*i +: 32];
               if (got !== want.f[i]) report_mismatch("rsp", i, got, want.f[i]);
            end
         end
      end
   end

   initial begin
      stim_row_type rows [$];
      link_type l;
      frame_type t;
      rows.push_back('{'{26'sd0, 32'sd0, 26'sd0, 32'sd65536}, 1'b1,
                       32'h00000000, 32'h00000000, 32'h00010000});
      rows.push_back('{'{26'sd0, 32'sd0, 26'sd5898240, 32'sd0}, 1'b0, '0, '0, '0});
      rows.push_back('{'{26'sd5898240, 32'sd65536, 26'sd11796480, -32'sd1}, 1'b0,
                       '0, '0, '0});
      rows.push_back('{'{-26'sd5898240, 32'h80000000, -26'sd11796480, 32'h7FFFFFFF},
                       1'b0, '0, '0, '0});
      rows.push_back('{'{26'sd23592960, 32'h7FFFFFFF, -26'sd23592960, 32'h80000000},
                       1'b0, '0, '0, '0});
      rows.push_back('{'{26'h1FFFFFF, 32'h80000000, 26'h2000000, 32'sd0}, 1'b0,
                       '0, '0, '0});
      rows.push_back('{'{26'h2000000, 32'h80000000, 26'h1FFFFFF, 32'sd1}, 1'b0,
                       '0, '0, '0});
      rows.push_back('{'{26'sd5898241, 32'h7FFFFFFF, 26'sd5898239, 32'sd0}, 1'b0,
                       '0, '0, '0});
      rows.push_back('{'{26'sd2949120, 32'sd6553600, 26'sd8847360, 32'sd123}, 1'b0,
                       '0, '0, '0});
      rows.push_back('{'{-26'sd20643840, 32'h80000000, 26'sd17694720, 32'sd0}, 1'b0,
                       '0, '0, '0});
      rows.push_back('{'{26'sd1, 32'sd1, -26'sd1, 32'sd0}, 1'b0, '0, '0, '0});
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (rows[k]) begin
         if (rows[k].fixed) begin
            t = link_transform(rows[k].link);
            if (t.f[8] !== rows[k].rot20) report_mismatch("table", 8, t.f[8], rows[k].rot20);
            if (t.f[3] !== rows[k].pos_x) report_mismatch("table", 3, t.f[3], rows[k].pos_x);
            if (t.f[11] !== rows[k].pos_z) report_mismatch("table", 11, t.f[11], rows[k].pos_z);
         end
         send_link(rows[k].link);
      end
      for (int n = 0; n < N_RANDOM; n++) begin
         calm = (n >= 400 && n < 550);
         l.offset = $urandom;
         l.length = $urandom_range(3) == 0 ? ($urandom_range(1) ? 32'h80000000 : 32'h7FFFFFFF)
                                          : $urandom;
         l.angle = rand_angle();
         l.twist = rand_angle();
         send_link(l);
      end
      req_tvalid <= 1'b0;
      calm = 1'b0;
      while (frame_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (n_errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/dlt_pkg.sv
hw/rtl/dlt_angle.sv
hw/rtl/dlt_cordic.sv
hw/rtl/dlt_product.sv
hw/rtl/dh_link_transform.sv
hw/rtl/dlt_checker.sv
sim/tb_top.sv
